### sv/dqs_pkg.sv
// Shared constants, codes and types for the deque with search.
// No dependencies; every other file of the block but dqs_ram imports this package.
`default_nettype none

package dqs_pkg;

    localparam int DEPTH    = 16;
    localparam int PTR_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int DATA_W   = 32;
    localparam int FUNC_W   = 3;
    localparam int STATUS_W = 3;
    localparam int POS_W    = 4;
    localparam int COUNT_W  = 5;

    localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = FUNC_W'(0);
    localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = FUNC_W'(1);
    localparam logic [FUNC_W-1:0] FN_POP_FRONT  = FUNC_W'(2);
    localparam logic [FUNC_W-1:0] FN_POP_BACK   = FUNC_W'(3);
    localparam logic [FUNC_W-1:0] FN_SEARCH     = FUNC_W'(4);

    localparam logic [STATUS_W-1:0] STS_DONE     = STATUS_W'(0);
    localparam logic [STATUS_W-1:0] STS_EMPTY    = STATUS_W'(1);
    localparam logic [STATUS_W-1:0] STS_FULL     = STATUS_W'(2);
    localparam logic [STATUS_W-1:0] STS_FOUND    = STATUS_W'(3);
    localparam logic [STATUS_W-1:0] STS_NOTFOUND = STATUS_W'(4);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    found_position;
        logic [COUNT_W-1:0]  entry_count;
    } rsp_t;

    // top level -> sequencer
    typedef struct packed {
        logic accept;
        logic slot_free;
    } seq_ctl_t;

    // sequencer -> top level
    typedef struct packed {
        logic idle;
        logic done;
    } seq_sts_t;

endpackage

`default_nettype wire

### sv/deque_with_search.sv
// Push, pop and unused codes give their result beat in the cycle after acceptance.
// A search scans the stored values in state S_SCAN, from the front:
// the store is read one entry a cycle through its single read port and one comparator.
// One push or pop per cycle while results are taken; a search holds the block until done.
// Reset (rst_n, asynchronous, active low) empties the deque and drops any held result beat.
// Depends on dqs_pkg, dqs_seq and dqs_ram.
`default_nettype none

module deque_with_search (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                req_valid,
    output logic                                     req_stall,
    input  wire logic [dqs_pkg::FUNC_W-1:0]          func,
    input  wire logic signed [dqs_pkg::DATA_W-1:0]   item_value,
    output logic                                     rsp_valid,
    input  wire logic                                rsp_stall,
    output logic [dqs_pkg::STATUS_W-1:0]             status,
    output logic [dqs_pkg::POS_W-1:0]                found_position,
    output logic [dqs_pkg::COUNT_W-1:0]              entry_count
);
    import dqs_pkg::*;

    seq_ctl_t ctl;
    seq_sts_t sts;
    rsp_t     seq_rsp;

    logic     rsp_valid_reg, rsp_valid_next;
    rsp_t     rsp_reg,       rsp_next;
    logic     slot_free;

    // The output register frees up either when empty or when its beat leaves this edge,
    // so a new request may enter while the previous result is still being taken.
    assign slot_free     = !rsp_valid_reg || !rsp_stall;
    assign req_stall     = !(sts.idle && slot_free);
    assign ctl.accept    = req_valid && !req_stall;
    assign ctl.slot_free = slot_free;

    dqs_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .func       (func),
        .item_value (item_value),
        .sts        (sts),
        .rsp        (seq_rsp)
    );

    // Load a finished result; otherwise drop the beat once the consumer takes it.
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        priority if (sts.done)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = seq_rsp;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            // hold the stalled beat
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid      = rsp_valid_reg;
    assign status         = rsp_reg.status;
    assign found_position = rsp_reg.found_position;
    assign entry_count    = rsp_reg.entry_count;

    a_quick_result: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall && func != FN_SEARCH) |=> rsp_valid)
        else $error("push or pop did not produce a result beat");

    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        !sts.idle |-> req_stall)
        else $error("request taken while a search is in progress");

endmodule

`default_nettype wire

### sv/dqs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
`default_nettype none

module dqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rd_data_reg <= mem_reg[raddr];
    end

    assign rdata = rd_data_reg;

endmodule

`default_nettype wire

### sv/dqs_seq.sv
// Sequencer of the deque: ring front pointer, count, and the search scan that
// reuses one comparator over the store. Depends on dqs_pkg and dqs_ram.
`default_nettype none

module dqs_seq (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire dqs_pkg::seq_ctl_t               ctl,
    input  wire logic [dqs_pkg::FUNC_W-1:0]      func,
    input  wire logic signed [dqs_pkg::DATA_W-1:0] item_value,
    output dqs_pkg::seq_sts_t                    sts,
    output dqs_pkg::rsp_t                        rsp
);
    import dqs_pkg::*;

    localparam logic [CNT_W:0]   DEPTH_X  = (CNT_W + 1)'(DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_FIN  = 3'b100
    } seq_state_t;

    function automatic logic [PTR_W-1:0] ring_at(input logic [PTR_W-1:0] base,
                                                 input logic [CNT_W-1:0] offs);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(offs);
        if (sum >= DEPTH_X)
        begin
            sum = sum - DEPTH_X;
        end
        return sum[PTR_W-1:0];
    endfunction

    seq_state_t          state_reg,   state_next;
    logic [PTR_W-1:0]    front_reg,   front_next;
    logic [CNT_W-1:0]    count_reg,   count_next;
    logic [DATA_W-1:0]   key_reg,     key_next;
    logic [CNT_W-1:0]    iss_idx_reg, iss_idx_next;
    logic                cmp_vld_reg, cmp_vld_next;
    logic [PTR_W-1:0]    cmp_idx_reg, cmp_idx_next;
    rsp_t                res_reg,     res_next;

    logic                ram_we;
    logic [PTR_W-1:0]    ram_waddr;
    logic [PTR_W-1:0]    ram_raddr;
    logic [DATA_W-1:0]   ram_rdata;
    logic                hit;
    logic                last;
    logic                done;
    logic [STATUS_W-1:0] imm_status;
    rsp_t                imm_rsp;

    dqs_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ($unsigned(item_value)),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign hit  = cmp_vld_reg && (ram_rdata == key_reg);
    assign last = cmp_vld_reg && (CNT_W'(cmp_idx_reg) == (count_reg - CNT_W'(1)));

    always_comb
    begin
        state_next   = state_reg;
        front_next   = front_reg;
        count_next   = count_reg;
        key_next     = key_reg;
        iss_idx_next = iss_idx_reg;
        cmp_vld_next = cmp_vld_reg;
        cmp_idx_next = cmp_idx_reg;
        res_next     = res_reg;
        ram_we       = 1'b0;
        ram_waddr    = front_reg;
        ram_raddr    = ring_at(front_reg, iss_idx_reg);
        imm_status   = STS_DONE;
        done         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (ctl.accept)
                begin
                    done = 1'b1;
                    unique case (func)
                        FN_PUSH_FRONT:
                        begin
                            if (count_reg == FULL_CNT)
                            begin
                                imm_status = STS_FULL;
                            end
                            else
                            begin
                                front_next = (front_reg == '0) ? LAST_PTR
                                                               : front_reg - PTR_W'(1);
                                ram_we     = 1'b1;
                                ram_waddr  = front_next;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        FN_PUSH_BACK:
                        begin
                            if (count_reg == FULL_CNT)
                            begin
                                imm_status = STS_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = ring_at(front_reg, count_reg);
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        FN_POP_FRONT:
                        begin
                            if (count_reg == '0)
                            begin
                                imm_status = STS_EMPTY;
                            end
                            else
                            begin
                                front_next = (front_reg == LAST_PTR) ? '0
                                                                     : front_reg + PTR_W'(1);
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        FN_POP_BACK:
                        begin
                            if (count_reg == '0)
                            begin
                                imm_status = STS_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        FN_SEARCH:
                        begin
                            key_next = $unsigned(item_value);
                            if (count_reg == '0)
                            begin
                                imm_status = STS_NOTFOUND;
                            end
                            else
                            begin
                                done         = 1'b0;
                                state_next   = S_SCAN;
                                iss_idx_next = '0;
                                cmp_vld_next = 1'b0;
                            end
                        end
                        default:
                        begin
                            imm_status = STS_DONE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // issue the next read while comparing the previous one
                cmp_vld_next = (iss_idx_reg < count_reg);
                cmp_idx_next = iss_idx_reg[PTR_W-1:0];
                if (iss_idx_reg < count_reg)
                begin
                    iss_idx_next = iss_idx_reg + CNT_W'(1);
                end
                priority if (hit)
                begin
                    res_next.status         = STS_FOUND;
                    res_next.found_position = POS_W'(cmp_idx_reg);
                    res_next.entry_count    = COUNT_W'(count_reg);
                    state_next              = S_FIN;
                end
                else if (last)
                begin
                    res_next.status         = STS_NOTFOUND;
                    res_next.found_position = '0;
                    res_next.entry_count    = COUNT_W'(count_reg);
                    state_next              = S_FIN;
                end
                else
                begin
                    // keep scanning
                    state_next = S_SCAN;
                end
            end
            S_FIN:
            begin
                done = ctl.slot_free;
                if (ctl.slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign imm_rsp.status         = imm_status;
    assign imm_rsp.found_position = '0;
    assign imm_rsp.entry_count    = COUNT_W'(count_next);

    assign rsp      = (state_reg == S_FIN) ? res_reg : imm_rsp;
    assign sts.idle = (state_reg == S_IDLE);
    assign sts.done = done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            front_reg   <= '0;
            count_reg   <= '0;
            iss_idx_reg <= '0;
            cmp_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            front_reg   <= front_next;
            count_reg   <= count_next;
            iss_idx_reg <= iss_idx_next;
            cmp_vld_reg <= cmp_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        cmp_idx_reg <= cmp_idx_next;
        res_reg     <= res_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("stored count beyond depth");

    a_done_slot: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ctl.slot_free)
        else $error("result produced with no free output slot");

    a_cmp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && cmp_vld_reg) |-> (CNT_W'(cmp_idx_reg) < count_reg))
        else $error("search compares past the stored entries");

endmodule

`default_nettype wire

### bench/deque_with_search_test.sv
// Self-checking bench for deque_with_search: a directed table, then random traffic with
// bursty requests, a coin-toss or pattern result stall, all scored against a local predictor.
// Depends on dqs_pkg and the deque_with_search RTL.
`default_nettype none

module deque_with_search_test;

    import dqs_pkg::*;

    // Function codes the block ignores
    localparam logic [FUNC_W-1:0] FN_RSVD5 = FUNC_W'(5);
    localparam logic [FUNC_W-1:0] FN_RSVD6 = FUNC_W'(6);
    localparam logic [FUNC_W-1:0] FN_RSVD7 = FUNC_W'(7);

    localparam int RANDOM_ITEMS = 400;
    localparam int DRAIN_CYCLES = DEPTH + 8;
    // A search holds the block until it has scanned the store. Add the longest sender gap and
    // a long result stall, then allow for it many times over.
    localparam int CYCLE_LIMIT  = 200000;

    typedef enum logic [1:0] {FILL_UP, DRAIN_DOWN, MIXED} fill_mode_t;
    typedef enum logic [1:0] {STALL_NONE, STALL_COIN, STALL_PATTERN} stall_mode_t;

    // One directed row: the request, how often to repeat it (the value steps by one each
    // time), and a hand-typed result where it is obvious from the spec.
    typedef struct packed {
        logic [FUNC_W-1:0] fn;
        logic [DATA_W-1:0] val;
        int                reps;
        logic              typed;
        rsp_t              want;
    } stim_row_t;

    localparam int DIRECTED_COUNT = 24;
    localparam stim_row_t DIRECTED_ROWS [0:DIRECTED_COUNT-1] = '{
        // empty deque: pops fail, search misses, spare codes do nothing
        '{FN_POP_FRONT,  32'h0000_0000,  1, 1'b1, '{STS_EMPTY,    4'd0,  5'd0}},
        '{FN_POP_BACK,   32'hFFFF_FFFF,  1, 1'b1, '{STS_EMPTY,    4'd0,  5'd0}},
        '{FN_SEARCH,     32'h0000_0000,  1, 1'b1, '{STS_NOTFOUND, 4'd0,  5'd0}},
        '{FN_RSVD5,      32'h5555_5555,  1, 1'b1, '{STS_DONE,     4'd0,  5'd0}},
        '{FN_RSVD6,      32'hAAAA_AAAA,  1, 1'b1, '{STS_DONE,     4'd0,  5'd0}},
        '{FN_RSVD7,      32'h0000_0000,  1, 1'b1, '{STS_DONE,     4'd0,  5'd0}},
        // extremes at both ends; the front push wraps the ring pointer
        '{FN_PUSH_BACK,  32'h7FFF_FFFF,  1, 1'b1, '{STS_DONE,     4'd0,  5'd1}},
        '{FN_PUSH_FRONT, 32'h8000_0000,  1, 1'b1, '{STS_DONE,     4'd0,  5'd2}},
        '{FN_SEARCH,     32'h8000_0000,  1, 1'b1, '{STS_FOUND,    4'd0,  5'd2}},
        '{FN_SEARCH,     32'h7FFF_FFFF,  1, 1'b1, '{STS_FOUND,    4'd1,  5'd2}},
        '{FN_SEARCH,     32'h0000_0000,  1, 1'b0, '0},
        // fill up, then pushes at both ends are refused
        '{FN_PUSH_BACK,  32'd100,       14, 1'b0, '0},
        '{FN_PUSH_FRONT, 32'h5555_5555,  1, 1'b1, '{STS_FULL,     4'd0,  5'd16}},
        '{FN_PUSH_BACK,  32'hAAAA_AAAA,  1, 1'b1, '{STS_FULL,     4'd0,  5'd16}},
        '{FN_SEARCH,     32'd113,        1, 1'b0, '0},
        '{FN_SEARCH,     32'hAAAA_AAAA,  1, 1'b0, '0},
        '{FN_RSVD5,      32'h0000_0000,  1, 1'b1, '{STS_DONE,     4'd0,  5'd16}},
        '{FN_POP_FRONT,  32'h0000_0000,  1, 1'b0, '0},
        '{FN_POP_BACK,   32'h0000_0000,  1, 1'b0, '0},
        // duplicate value: the search reports the one nearest the front
        '{FN_PUSH_FRONT, 32'd100,        1, 1'b0, '0},
        '{FN_SEARCH,     32'd100,        1, 1'b0, '0},
        '{FN_POP_BACK,   32'h0000_0000, 15, 1'b0, '0},
        '{FN_POP_FRONT,  32'h0000_0000,  1, 1'b1, '{STS_EMPTY,    4'd0,  5'd0}},
        '{FN_SEARCH,     32'h8000_0000,  1, 1'b1, '{STS_NOTFOUND, 4'd0,  5'd0}}
    };

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              req_valid  = 1'b0;
    logic              req_stall;
    logic [FUNC_W-1:0] func       = FN_PUSH_FRONT;
    logic [DATA_W-1:0] item_value = '0;
    logic              rsp_valid;
    logic              rsp_stall  = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    found_position;
    logic [COUNT_W-1:0]  entry_count;

    // Predictor state: a private copy of the ring store, front pointer and fill count
    logic [DATA_W-1:0] model_store [DEPTH];
    logic [PTR_W-1:0]  model_front = '0;
    logic [CNT_W-1:0]  model_count = '0;

    rsp_t pending_results [$];
    int   failure_count = 0;
    int   cycle_count   = 0;
    int   burst_left    = 0;

    stall_mode_t stall_mode    = STALL_NONE;
    int          stall_left    = 0;
    logic [7:0]  stall_pattern = 8'h00;

    deque_with_search dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .func           (func),
        .item_value     (item_value),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .status         (status),
        .found_position (found_position),
        .entry_count    (entry_count)
    );

    always #5 clk = ~clk;

    // Apply one accepted request to the local deque and return the result it must give.
    function automatic rsp_t predict_deque_result(input logic [FUNC_W-1:0] fn,
                                                  input logic [DATA_W-1:0] val);
        rsp_t             res;
        logic [PTR_W-1:0] slot;
        int               i;
        res = '0;
        case (fn)
            FN_PUSH_FRONT, FN_PUSH_BACK:
            begin
                if (model_count >= CNT_W'(DEPTH))
                    res.status = STS_FULL;
                else
                begin
                    if (fn == FN_PUSH_FRONT)
                    begin
                        model_front = model_front - 1'b1;
                        slot = model_front;
                    end
                    else
                        slot = PTR_W'(model_front + model_count);
                    model_store[slot] = val;
                    model_count = model_count + 1'b1;
                end
            end
            FN_POP_FRONT, FN_POP_BACK:
            begin
                if (model_count == '0)
                    res.status = STS_EMPTY;
                else
                begin
                    if (fn == FN_POP_FRONT)
                        model_front = model_front + 1'b1;
                    model_count = model_count - 1'b1;
                end
            end
            FN_SEARCH:
            begin
                res.status = STS_NOTFOUND;
                for (i = 0; i < int'(model_count); i++)
                begin
                    if (res.status == STS_NOTFOUND
                        && model_store[PTR_W'(model_front + i)] == val)
                    begin
                        res.status = STS_FOUND;
                        res.found_position = POS_W'(i);
                    end
                end
            end
            default:
            begin
            end
        endcase
        res.entry_count = COUNT_W'(model_count);
        return res;
    endfunction

    // Small pool for duplicates, the corner values, otherwise anything
    function automatic logic [DATA_W-1:0] random_item_value();
        logic [DATA_W-1:0] v;
        case ($urandom_range(0, 7))
            0, 1: v = DATA_W'($urandom_range(0, 7));
            2:
            begin
                case ($urandom_range(0, 3))
                    0:       v = 32'h8000_0000;
                    1:       v = 32'h7FFF_FFFF;
                    2:       v = 32'hFFFF_FFFF;
                    default: v = 32'h0000_0000;
                endcase
            end
            default: v = $urandom();
        endcase
        return v;
    endfunction

    task automatic note_failure(input string msg);
        failure_count++;
        if (failure_count <= 10)
            $display("%s", msg);
    endtask

    // Present one request beat and hold it until the block takes it
    task automatic send_request(input logic [FUNC_W-1:0] fn, input logic [DATA_W-1:0] val);
        @(negedge clk);
        req_valid  <= 1'b1;
        func       <= fn;
        item_value <= val;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    // Bursts of random length; between bursts drop valid for a few cycles.
    // Some bursts are long, giving stretches of back-to-back requests.
    task automatic pace_sender();
        int gap;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
            gap = $urandom_range(1, 8);
            @(negedge clk);
            req_valid <= 1'b0;
            repeat (gap - 1)
                @(negedge clk);
        end
    endtask

    // Result side: stall on a mode that changes every so often - no stall, coin toss,
    // or a rotating 8-bit pattern.
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode    = stall_mode_t'($urandom_range(0, 2));
            stall_left    = $urandom_range(20, 100);
            stall_pattern = 8'($urandom());
        end
        stall_left--;
        case (stall_mode)
            STALL_COIN:    rsp_stall <= 1'($urandom_range(0, 1));
            STALL_PATTERN:
            begin
                rsp_stall <= stall_pattern[0];
                stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
            end
            default:       rsp_stall <= 1'b0;
        endcase
    end

    // Score every accepted result beat against the oldest expectation
    always @(posedge clk)
    begin
        rsp_t got;
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            got.status         = status;
            got.found_position = found_position;
            got.entry_count    = entry_count;
            if (pending_results.size() == 0)
                note_failure($sformatf("unexpected result beat: status %0d pos %0d count %0d",
                                       got.status, got.found_position, got.entry_count));
            else
            begin
                want = pending_results.pop_front();
                if (got.status !== want.status
                    || got.found_position !== want.found_position
                    || got.entry_count !== want.entry_count)
                    note_failure($sformatf({"result mismatch: expected status %0d pos %0d ",
                                            "count %0d, got status %0d pos %0d count %0d"},
                                           want.status, want.found_position, want.entry_count,
                                           got.status, got.found_position, got.entry_count));
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        int                row_idx;
        int                rep_idx;
        int                useful_sent;
        int                mode_left;
        int                grow_pct;
        int                roll;
        fill_mode_t        fill_mode;
        logic [FUNC_W-1:0] pick_fn;
        logic [DATA_W-1:0] pick_val;
        rsp_t              predicted;

        useful_sent = 0;
        mode_left   = 0;
        fill_mode   = MIXED;

        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table: typed results where obvious, the predictor elsewhere
        for (row_idx = 0; row_idx < DIRECTED_COUNT; row_idx++)
        begin
            for (rep_idx = 0; rep_idx < DIRECTED_ROWS[row_idx].reps; rep_idx++)
            begin
                pick_fn  = DIRECTED_ROWS[row_idx].fn;
                pick_val = DIRECTED_ROWS[row_idx].val + DATA_W'(rep_idx);
                send_request(pick_fn, pick_val);
                predicted = predict_deque_result(pick_fn, pick_val);
                pending_results.push_back(DIRECTED_ROWS[row_idx].typed
                                          ? DIRECTED_ROWS[row_idx].want : predicted);
                pace_sender();
            end
        end

        // Random traffic. Swing between filling and draining phases so the deque
        // regularly hits both full and empty; searches mostly aim at stored values.
        while (useful_sent < RANDOM_ITEMS)
        begin
            if (mode_left == 0)
            begin
                fill_mode = fill_mode_t'($urandom_range(0, 2));
                mode_left = $urandom_range(8, 40);
            end
            mode_left--;

            roll = $urandom_range(0, 99);
            if (roll < 3)
            begin
                case ($urandom_range(0, 2))
                    0:       pick_fn = FN_RSVD5;
                    1:       pick_fn = FN_RSVD6;
                    default: pick_fn = FN_RSVD7;
                endcase
            end
            else if (roll < 23)
                pick_fn = FN_SEARCH;
            else
            begin
                grow_pct = (fill_mode == FILL_UP) ? 75 : (fill_mode == DRAIN_DOWN) ? 25 : 50;
                if ($urandom_range(0, 99) < grow_pct)
                    pick_fn = $urandom_range(0, 1) ? FN_PUSH_BACK : FN_PUSH_FRONT;
                else
                    pick_fn = $urandom_range(0, 1) ? FN_POP_BACK : FN_POP_FRONT;
            end

            if (pick_fn == FN_SEARCH && model_count != '0 && $urandom_range(0, 9) < 6)
                pick_val = model_store[PTR_W'(model_front
                                              + $urandom_range(0, model_count - 1))];
            else
                pick_val = random_item_value();

            send_request(pick_fn, pick_val);
            pending_results.push_back(predict_deque_result(pick_fn, pick_val));
            if (pick_fn <= FN_SEARCH)
                useful_sent++;
            pace_sender();
        end

        // Drain: wait for every expected beat, then watch a while for strays
        @(negedge clk);
        req_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (failure_count == 0 && pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
